[rtl/page_replacement_lru_clock_macros.svh]
// ----------------------------------------------------------------------------
// Page replacement assertion macros
// Shared concurrent assertion forms for the page replacement unit.
// ----------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_LRU_CLOCK_MACROS_SVH
`define PAGE_REPLACEMENT_LRU_CLOCK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRLC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("page replacement: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("page replacement: next-cycle check failed");

`endif

[rtl/prlc_pkg.sv]
// ----------------------------------------------------------------------------
// Page replacement package
// Sizes, register indexes, policy codes and the structs shared by the cells.
// ----------------------------------------------------------------------------
package prlc_pkg;

  // Built frame count and page number width.
  localparam int unsigned MAX_FRAMES = 16;
  localparam int unsigned PAGE_BITS  = 16;

  // Derived widths.
  localparam int unsigned FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned COUNT_W = $clog2(MAX_FRAMES + 1);

  // Fixed widths of the ports.
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned FAULT_W     = 32;
  localparam int unsigned PAGE_IO_W   = 16;
  localparam int unsigned FRAME_OUT_W = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [STAMP_W-1:0]     stamp_t;
  typedef logic [FAULT_W-1:0]     fault_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [FRAME_OUT_W-1:0] frame_out_t;
  typedef logic [PAGE_IO_W-1:0]   page_io_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;

  // Policy codes.
  localparam logic POLICY_LRU   = 1'b0;
  localparam logic POLICY_CLOCK = 1'b1;

  // Reset value of the frame count register.
  localparam cfg_data_t FRAMES_RESET = 5'd16;

  // Search word passed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic   valid;
    count_t idx;
    logic   found;
    frame_t where;
    logic   have_min;
    stamp_t best_stamp;
    frame_t best_idx;
    page_t  best_page;
  } wave_t;

  // Request context broadcast to every cell while a word is in work.
  typedef struct packed {
    page_t  page;
    stamp_t stamp;
    count_t live;
    count_t eff;
    logic   clock_mode;
  } req_t;

  // Per-cell write controls.
  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctrl_t;

endpackage

[rtl/prlc_cell.sv]
// ----------------------------------------------------------------------------
// Page replacement frame cell
// Holds one frame (page, last-use stamp, reference bit) and updates the search
// word that passes through it on its way down the chain.
// ----------------------------------------------------------------------------
module prlc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prlc_pkg::wave_t      wave_i,
  output prlc_pkg::wave_t      wave_o,
  input  prlc_pkg::req_t       req_i,
  input  prlc_pkg::cell_ctrl_t ctrl_i,
  output prlc_pkg::page_t      page_o,
  output logic                 ref_o
);

  prlc_pkg::page_t  page_q;
  prlc_pkg::stamp_t stamp_q;
  logic             ref_q;
  prlc_pkg::wave_t  wave_d;
  prlc_pkg::wave_t  wave_q;
  logic             in_live;
  logic             in_eff;
  logic             match;

  // Compare this frame against the request and fold it into the search word.
  always_comb begin
    in_live = (wave_i.idx < req_i.live);
    in_eff  = (wave_i.idx < req_i.eff);
    match   = wave_i.valid && in_live && (page_q == req_i.page);
    wave_d      = wave_i;
    wave_d.idx  = wave_i.idx + prlc_pkg::count_t'(1);
    if (!wave_i.found && match) begin
      wave_d.found = 1'b1;
      wave_d.where = prlc_pkg::frame_t'(wave_i.idx);
    end
    // Strict less-than keeps the lowest index on equal stamps.
    if (in_eff && (!wave_i.have_min || (stamp_q < wave_i.best_stamp))) begin
      wave_d.have_min   = 1'b1;
      wave_d.best_stamp = stamp_q;
      wave_d.best_idx   = prlc_pkg::frame_t'(wave_i.idx);
      wave_d.best_page  = page_q;
    end
  end

  // Search word register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  // Frame contents: loaded on a fill or eviction, stamp refreshed on a hit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      page_q  <= req_i.page;
      stamp_q <= req_i.stamp;
    end else if (match) begin
      stamp_q <= req_i.stamp;
    end
  end

  // Reference bit: set by a hit in clock mode, cleared by a load or the hand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 1'b0;
    end else if (ctrl_i.load || ctrl_i.clear) begin
      ref_q <= 1'b0;
    end else if (match && req_i.clock_mode) begin
      ref_q <= 1'b1;
    end
  end

  assign wave_o = wave_q;
  assign page_o = page_q;
  assign ref_o  = ref_q;

endmodule

[rtl/page_replacement_lru_clock.sv]
// ----------------------------------------------------------------------------
// Page replacement unit, LRU or CLOCK
// Looks up one page reference per word in a chain of frame cells, reports a
// hit or fills or replaces a frame, and keeps a saturating fault count.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  config    cfg_we_i             cfg_idx_i, cfg_data_i
//  request   start, busy          page_number_i
//  result    result_valid_o       hit_o, frame_index_o, evicted_valid_o,
//                                 evicted_page_o, fault_count_o
//
// A request word walks the chain of MAX_FRAMES cells, one cell per cycle, before
// a hit, a fill or an LRU eviction delivers its result. A CLOCK eviction then
// steps the hand one frame per cycle over the first N frames, where N is
// frames_in_use held to the range 1..MAX_FRAMES.
// busy stays high from acceptance until the result strobe; words are taken
// one at a time. Reset clears the fill count, hand, stamps counter, fault
// count and all reference bits. The result strobe lasts one cycle and is
// never held off.
// ----------------------------------------------------------------------------
`include "page_replacement_lru_clock_macros.svh"

module page_replacement_lru_clock (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [prlc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  prlc_pkg::cfg_data_t                   cfg_data_i,
  input  logic                                  start,
  output logic                                  busy,
  input  prlc_pkg::page_io_t                    page_number_i,
  output logic                                  result_valid_o,
  output logic                                  hit_o,
  output prlc_pkg::frame_out_t                  frame_index_o,
  output logic                                  evicted_valid_o,
  output prlc_pkg::page_io_t                    evicted_page_o,
  output prlc_pkg::fault_t                      fault_count_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  // Configuration registers.
  logic                policy_q;
  prlc_pkg::cfg_data_t frames_q;

  // Control state.
  logic [1:0]        state_q, state_d;
  logic              head_q, head_d;
  prlc_pkg::count_t  filled_q, filled_d;
  prlc_pkg::frame_t  hand_q, hand_d;
  prlc_pkg::stamp_t  stamp_q, stamp_d;
  prlc_pkg::fault_t  faults_q, faults_d;

  // Request context.
  prlc_pkg::page_t   req_page_q, req_page_d;
  prlc_pkg::count_t  eff_q, eff_d;
  prlc_pkg::count_t  live_q, live_d;

  // Result registers.
  logic                 res_valid_q;
  logic                 hit_q, hit_d;
  prlc_pkg::frame_out_t frame_q;
  logic                 ev_valid_q, ev_valid_d;
  prlc_pkg::page_io_t   ev_page_q;
  prlc_pkg::fault_t     fault_out_q;

  // Decision logic.
  logic              emit;
  logic              load_en;
  logic              clr_en;
  prlc_pkg::frame_t  load_idx;
  prlc_pkg::frame_t  where_d;
  prlc_pkg::page_t   ev_page_d;
  prlc_pkg::frame_t  hand_next;
  prlc_pkg::count_t  eff_cfg;
  prlc_pkg::count_t  live_cfg;

  // Cell chain.
  prlc_pkg::req_t       req;
  prlc_pkg::wave_t      head_wave;
  prlc_pkg::wave_t      tail;
  prlc_pkg::wave_t      wave_in  [prlc_pkg::MAX_FRAMES];
  prlc_pkg::wave_t      wave_out [prlc_pkg::MAX_FRAMES];
  prlc_pkg::cell_ctrl_t ctrl     [prlc_pkg::MAX_FRAMES];
  prlc_pkg::page_t      page_vec [prlc_pkg::MAX_FRAMES];
  logic [prlc_pkg::MAX_FRAMES-1:0] ref_vec;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= prlc_pkg::POLICY_LRU;
      frames_q <= prlc_pkg::FRAMES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prlc_pkg::REG_POLICY: policy_q <= cfg_data_i[0];
        prlc_pkg::REG_FRAMES: frames_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame count and the number of filled frames to search.
  always_comb begin
    if (frames_q == '0) begin
      eff_cfg = prlc_pkg::count_t'(1);
    end else if (32'(frames_q) > 32'(prlc_pkg::MAX_FRAMES)) begin
      eff_cfg = prlc_pkg::count_t'(prlc_pkg::MAX_FRAMES);
    end else begin
      eff_cfg = prlc_pkg::count_t'(frames_q);
    end
    live_cfg = (filled_q < eff_cfg) ? filled_q : eff_cfg;
  end

  // Context broadcast to the cells and the search word entering the chain.
  always_comb begin
    req.page       = req_page_q;
    req.stamp      = stamp_q;
    req.live       = live_q;
    req.eff        = eff_q;
    req.clock_mode = (policy_q == prlc_pkg::POLICY_CLOCK);
    head_wave       = '0;
    head_wave.valid = head_q;
  end

  // Row of frame cells.
  for (genvar k = 0; k < prlc_pkg::MAX_FRAMES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign wave_in[k] = head_wave;
    end else begin : g_link
      assign wave_in[k] = wave_out[k-1];
    end

    assign ctrl[k] = '{load:  load_en && (load_idx == prlc_pkg::frame_t'(k)),
                       clear: clr_en && (hand_q == prlc_pkg::frame_t'(k))};

    prlc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wave_i (wave_in[k]),
      .wave_o (wave_out[k]),
      .req_i  (req),
      .ctrl_i (ctrl[k]),
      .page_o (page_vec[k]),
      .ref_o  (ref_vec[k])
    );
  end

  assign tail = wave_out[prlc_pkg::MAX_FRAMES-1];

  // Sequencer: launch the search, decide at the tail, step the clock hand.
  always_comb begin
    state_d    = state_q;
    head_d     = 1'b0;
    filled_d   = filled_q;
    hand_d     = hand_q;
    stamp_d    = stamp_q;
    faults_d   = faults_q;
    req_page_d = req_page_q;
    eff_d      = eff_q;
    live_d     = live_q;
    emit       = 1'b0;
    load_en    = 1'b0;
    clr_en     = 1'b0;
    load_idx   = hand_q;
    where_d    = '0;
    hit_d      = 1'b0;
    ev_valid_d = 1'b0;
    ev_page_d  = '0;

    if (32'(hand_q) + 32'd1 >= 32'(eff_q)) begin
      hand_next = '0;
    end else begin
      hand_next = hand_q + prlc_pkg::frame_t'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_page_d = prlc_pkg::page_t'(page_number_i);
          eff_d      = eff_cfg;
          live_d     = live_cfg;
          head_d     = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          if (tail.found) begin
            emit    = 1'b1;
            hit_d   = 1'b1;
            where_d = tail.where;
          end else begin
            faults_d = (faults_q == '1) ? faults_q : faults_q + prlc_pkg::fault_t'(1);
            if (filled_q < eff_q) begin
              // A free frame remains: fill it.
              where_d  = prlc_pkg::frame_t'(filled_q);
              load_idx = prlc_pkg::frame_t'(filled_q);
              load_en  = 1'b1;
              filled_d = filled_q + prlc_pkg::count_t'(1);
              emit     = 1'b1;
            end else if (policy_q == prlc_pkg::POLICY_LRU) begin
              where_d    = tail.best_idx;
              load_idx   = tail.best_idx;
              load_en    = 1'b1;
              ev_valid_d = 1'b1;
              ev_page_d  = tail.best_page;
              emit       = 1'b1;
            end else begin
              // Clock eviction: restart a hand that lies past the frame count.
              state_d = ST_SWEEP;
              if (32'(hand_q) >= 32'(eff_q)) begin
                hand_d = '0;
              end
            end
          end
        end
      end
      ST_SWEEP: begin
        if (ref_vec[hand_q]) begin
          clr_en = 1'b1;
          hand_d = hand_next;
        end else begin
          where_d    = hand_q;
          load_idx   = hand_q;
          load_en    = 1'b1;
          ev_valid_d = 1'b1;
          ev_page_d  = page_vec[hand_q];
          hand_d     = hand_next;
          emit       = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      state_d = ST_IDLE;
      stamp_d = (stamp_q == '1) ? stamp_q : stamp_q + prlc_pkg::stamp_t'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= 1'b0;
      filled_q    <= '0;
      hand_q      <= '0;
      stamp_q     <= '0;
      faults_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      filled_q    <= filled_d;
      hand_q      <= hand_d;
      stamp_q     <= stamp_d;
      faults_q    <= faults_d;
      res_valid_q <= emit;
    end
  end

  // Request context and result words.
  always_ff @(posedge clk_i) begin
    req_page_q <= req_page_d;
    eff_q      <= eff_d;
    live_q     <= live_d;
    if (emit) begin
      hit_q       <= hit_d;
      frame_q     <= prlc_pkg::frame_out_t'(where_d);
      ev_valid_q  <= ev_valid_d;
      ev_page_q   <= prlc_pkg::page_io_t'(ev_page_d);
      fault_out_q <= faults_d;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = res_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;

  // A result word is only shown once the sequencer is back to idle.
  `PRLC_ASSERT_IMPL(a_result_idle, clk_i, rst_ni, result_valid_o, !busy)
  // The search word reaches the end of the chain only during a lookup.
  `PRLC_ASSERT_IMPL(a_tail_in_scan, clk_i, rst_ni, tail.valid, state_q == ST_SCAN)
  // The clock hand stays inside the managed frames while it sweeps.
  `PRLC_ASSERT_IMPL(a_hand_range, clk_i, rst_ni, state_q == ST_SWEEP, 32'(hand_q) < 32'(eff_q))
  // An accepted word launches a search down the chain.
  `PRLC_ASSERT_NEXT(a_launch, clk_i, rst_ni, start && !busy, head_q && busy)

endmodule
